[src/sts_pkg.sv]
// Package for the script token scanner: constants, scan modes, token kinds,
// result record type. No dependencies.
`default_nettype none
package sts_pkg;
  localparam int unsigned PosBits  = 16;
  localparam int unsigned WordBytes = 8;
  localparam int unsigned LenBits  = 16;

  localparam logic [3:0] M_IDLE   = 4'd0;
  localparam logic [3:0] M_ID     = 4'd1;
  localparam logic [3:0] M_NUM    = 4'd2;
  localparam logic [3:0] M_BADNUM = 4'd3;
  localparam logic [3:0] M_SLASH  = 4'd4;
  localparam logic [3:0] M_LINE   = 4'd5;
  localparam logic [3:0] M_BLOCK  = 4'd6;
  localparam logic [3:0] M_BSTAR  = 4'd7;
  localparam logic [3:0] M_STR2   = 4'd8;
  localparam logic [3:0] M_STR1   = 4'd9;

  localparam logic [4:0] K_ID      = 5'd0;
  localparam logic [4:0] K_VAR     = 5'd1;
  localparam logic [4:0] K_CONST   = 5'd2;
  localparam logic [4:0] K_FUNC    = 5'd3;
  localparam logic [4:0] K_IF      = 5'd4;
  localparam logic [4:0] K_ELSE    = 5'd5;
  localparam logic [4:0] K_WHILE   = 5'd6;
  localparam logic [4:0] K_RETURN  = 5'd7;
  localparam logic [4:0] K_TRUE    = 5'd8;
  localparam logic [4:0] K_FALSE   = 5'd9;
  localparam logic [4:0] K_ALERT   = 5'd10;
  localparam logic [4:0] K_INT     = 5'd11;
  localparam logic [4:0] K_DEC     = 5'd12;
  localparam logic [4:0] K_STR     = 5'd13;
  localparam logic [4:0] K_COMMENT = 5'd14;
  localparam logic [4:0] K_UNDEF   = 5'd15;
  localparam logic [4:0] K_EOF     = 5'd16;
  localparam logic [4:0] K_PUNCT0  = 5'd17;
  localparam logic [4:0] K_DIV     = 5'd22;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_TAB   = 8'd9;
  localparam logic [7:0] CH_DOT   = 8'd46;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_STAR  = 8'd42;
  localparam logic [7:0] CH_DQ    = 8'd34;
  localparam logic [7:0] CH_SQ    = 8'd39;
  localparam logic [7:0] CH_US    = 8'd95;
  localparam logic [7:0] CH_DOLLAR = 8'd36;

  localparam logic [4:0] TabReset = 5'd4;

  typedef struct packed {
    logic [4:0]          kind;
    logic [PosBits-1:0]  row;
    logic [PosBits-1:0]  col;
    logic [LenBits-1:0]  len;
  } token_t;

  typedef logic [WordBytes-1:0][7:0] word_t;

  function automatic logic is_alpha(input logic [7:0] b);
    return (b >= 8'd65 && b <= 8'd90) || (b >= 8'd97 && b <= 8'd122);
  endfunction

  function automatic logic is_digit(input logic [7:0] b);
    return b >= 8'd48 && b <= 8'd57;
  endfunction

  function automatic logic is_blank(input logic [7:0] b);
    return b == 8'd32 || (b >= 8'd9 && b <= 8'd13);
  endfunction

  // Punctuation mark index, 14 when the byte is not one.
  function automatic logic [3:0] punct_idx(input logic [7:0] b);
    logic [3:0] r;
    case (b)
      8'd40:  r = 4'd0;
      8'd41:  r = 4'd1;
      8'd42:  r = 4'd2;
      8'd43:  r = 4'd3;
      8'd45:  r = 4'd4;
      8'd47:  r = 4'd5;
      8'd59:  r = 4'd6;
      8'd60:  r = 4'd7;
      8'd61:  r = 4'd8;
      8'd62:  r = 4'd9;
      8'd91:  r = 4'd10;
      8'd93:  r = 4'd11;
      8'd123: r = 4'd12;
      8'd125: r = 4'd13;
      default: r = 4'd14;
    endcase
    return r;
  endfunction
endpackage
`default_nettype wire

[src/sts_keyword.sv]
// Keyword matcher: compares the word buffer against the ten keywords.
// Depends on sts_pkg.
`default_nettype none
module sts_keyword (
  input  wire sts_pkg::word_t                word_i,
  input  wire logic [sts_pkg::LenBits-1:0]   len_i,
  output logic [4:0]                          kind_o
);
  logic [4:0] k;

  function automatic logic eq(input sts_pkg::word_t w, input logic [63:0] s, input int n);
    logic r;
    r = 1'b1;
    for (int i = 0; i < 8; i++)
      if (i < n && w[i] != s[8*i +: 8]) r = 1'b0;
    return r;
  endfunction

  // keyword strings stored first byte lowest
  always_comb begin
    k = sts_pkg::K_ID;
    case (len_i)
      16'd2: if (eq(word_i, {48'd0, "fi"}, 2)) k = sts_pkg::K_IF;
      16'd3: if (eq(word_i, {40'd0, "rav"}, 3)) k = sts_pkg::K_VAR;
      16'd4: begin
        if (eq(word_i, {32'd0, "esle"}, 4)) k = sts_pkg::K_ELSE;
        else if (eq(word_i, {32'd0, "eurt"}, 4)) k = sts_pkg::K_TRUE;
      end
      16'd5: begin
        if (eq(word_i, {24'd0, "tsnoc"}, 5)) k = sts_pkg::K_CONST;
        else if (eq(word_i, {24'd0, "elihw"}, 5)) k = sts_pkg::K_WHILE;
        else if (eq(word_i, {24'd0, "eslaf"}, 5)) k = sts_pkg::K_FALSE;
        else if (eq(word_i, {24'd0, "trela"}, 5)) k = sts_pkg::K_ALERT;
      end
      16'd6: if (eq(word_i, {16'd0, "nruter"}, 6)) k = sts_pkg::K_RETURN;
      16'd8: if (eq(word_i, "noitcnuf", 8)) k = sts_pkg::K_FUNC;
      default: k = sts_pkg::K_ID;
    endcase
  end
  assign kind_o = k;
endmodule
`default_nettype wire

[src/sts_out_queue.sv]
// Four-entry result queue with skid space: holds the scanner's tokens and
// tells the scanner when another byte may enter. Depends on sts_pkg.
`default_nettype none
module sts_out_queue (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [1:0]       cnt_i,
  input  wire sts_pkg::token_t  tok0_i,
  input  wire sts_pkg::token_t  tok1_i,
  output logic                  room_o,
  output logic                  valid_o,
  input  wire logic             ready_i,
  output sts_pkg::token_t       tok_o,
  output logic                  last_o
);
  sts_pkg::token_t mem_q [4];
  logic            lst_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] fill_q, fill_d;
  logic pop;

  assign valid_o = fill_q != 3'd0;
  assign pop     = valid_o && ready_i;
  assign tok_o   = mem_q[rp_q];
  assign last_o  = lst_q[rp_q];
  // a byte can bring two tokens, so take one only with two free slots
  assign room_o  = fill_q <= 3'd2;
  assign fill_d  = fill_q + (push_i ? {1'b0, cnt_i} : 3'd0) - {2'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      fill_q <= '0;
    end else begin
      fill_q <= fill_d;
      if (pop) rp_q <= rp_q + 2'd1;
      if (push_i) wp_q <= wp_q + cnt_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i && cnt_i != 2'd0) begin
      mem_q[wp_q] <= tok0_i;
      lst_q[wp_q] <= cnt_i == 2'd1;
      if (cnt_i == 2'd2) begin
        mem_q[wp_q + 2'd1] <= tok1_i;
        lst_q[wp_q + 2'd1] <= 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk_i) disable iff (!rst_ni) fill_q <= 3'd4)
    else $error("result queue overflow");
  a_push_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> room_o) else $error("push without room");
  a_fill_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> fill_q == $past(fill_d)) else $error("fill mismatch");
`endif
endmodule
`default_nettype wire

[src/script_token_scanner_core.sv]
// Top level of the script token scanner: scan state, position counters and
// per-byte token logic. Depends on sts_pkg, sts_keyword, sts_out_queue.
//
//  channel  | dir | handshake            | payload
//  s_axis   | in  | tvalid/tready        | tdata[7:0] text_byte, tuser end_of_text
//  m_axis   | out | tvalid/tready        | tdata[55:0] kind,row,col,len; tlast
//  cfg      | in  | cfg_we_i             | cfg_data_i[4:0] tab_advance
// One byte is taken every cycle while the result queue has two free slots.
// A request's tokens are registered in the result queue on acceptance.
// Reset clears scan state; the word buffer holds junk until written.
// An output stall fills the four-slot queue, then stops input.
`default_nettype none
module script_token_scanner_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [4:0]  cfg_data_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] text_byte
  input  wire logic        s_axis_tuser,   // end_of_text
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [55:0]      m_axis_tdata,   // kind[4:0], row[20:5], col[36:21], len[52:37]
  output logic             m_axis_tlast    // last_of_run
);
  localparam int unsigned PB = sts_pkg::PosBits;
  localparam int unsigned LB = sts_pkg::LenBits;
  localparam logic [PB-1:0] PosMax = '1;
  localparam logic [LB-1:0] LenMax = '1;

  logic [4:0] tab_q;
  logic [3:0] mode_q, mode_d;
  logic [PB-1:0] row_q, row_d, col_q, col_d, trow_q, trow_d, tcol_q, tcol_d;
  logic [LB-1:0] tlen_q, tlen_d, glen;
  sts_pkg::word_t wbuf_q, wbuf_d;
  logic dot_q, dot_d, eof_q, eof_d;
  logic [1:0] n;
  sts_pkg::token_t t0, t1, tnew;
  logic [4:0] kwkind;
  logic room, acc;
  logic [7:0] b;
  logic [PB-1:0] c;
  logic consumed, flushit, idch;
  logic [3:0] pi;
  logic [PB:0] tsum;

  sts_keyword u_kw (.word_i(wbuf_q), .len_i(tlen_q), .kind_o(kwkind));

  assign s_axis_tready = room;
  assign acc = s_axis_tvalid && room;
  assign b = s_axis_tdata;
  assign c = (col_q == PosMax) ? PosMax : col_q + 1'b1;
  assign glen = (tlen_q == LenMax) ? LenMax : tlen_q + 1'b1;
  assign idch = sts_pkg::is_alpha(b) || sts_pkg::is_digit(b) || b == sts_pkg::CH_US
             || b == sts_pkg::CH_DOLLAR;
  assign pi = sts_pkg::punct_idx(b);
  assign tsum = {1'b0, col_q} + {{(PB-4){1'b0}}, tab_q};

  function automatic sts_pkg::token_t mk(input logic [4:0] k, input logic [PB-1:0] r,
                                         input logic [PB-1:0] cc, input logic [LB-1:0] l);
    sts_pkg::token_t t;
    t.kind = k; t.row = r; t.col = cc; t.len = l;
    return t;
  endfunction

  always_comb begin
    mode_d = mode_q; row_d = row_q; col_d = col_q; trow_d = trow_q; tcol_d = tcol_q;
    tlen_d = tlen_q; wbuf_d = wbuf_q; dot_d = dot_q; eof_d = eof_q;
    n = 2'd0; t0 = '0; t1 = '0; tnew = '0;
    consumed = 1'b0; flushit = 1'b0;
    // pending token as it stands
    case (mode_q)
      sts_pkg::M_ID:    tnew = mk(kwkind, trow_q, tcol_q, tlen_q);
      sts_pkg::M_NUM:   tnew = mk(dot_q ? sts_pkg::K_DEC : sts_pkg::K_INT, trow_q, tcol_q, tlen_q);
      sts_pkg::M_SLASH: tnew = mk(sts_pkg::K_DIV, trow_q, tcol_q, tlen_q);
      sts_pkg::M_LINE:  tnew = mk(sts_pkg::K_COMMENT, trow_q, tcol_q, tlen_q);
      default:          tnew = mk(sts_pkg::K_UNDEF, trow_q, tcol_q, tlen_q);
    endcase
    if (!eof_q) begin
      if (s_axis_tuser) begin
        if (mode_q != sts_pkg::M_IDLE) begin
          t0 = tnew; n = 2'd1;
        end
        if (n == 2'd0) t0 = mk(sts_pkg::K_EOF, row_q, c, '0);
        else t1 = mk(sts_pkg::K_EOF, row_q, c, '0);
        n = n + 2'd1;
        mode_d = sts_pkg::M_IDLE;
        eof_d = 1'b1;
      end else begin
        case (mode_q)
          sts_pkg::M_ID: begin
            if (idch) begin
              consumed = 1'b1;
              if (tlen_q < LB'(sts_pkg::WordBytes))
                wbuf_d[tlen_q[$clog2(sts_pkg::WordBytes)-1:0]] = b;
            end else flushit = 1'b1;
          end
          sts_pkg::M_NUM: begin
            if (sts_pkg::is_alpha(b) || (b == sts_pkg::CH_DOT && dot_q)) begin
              mode_d = sts_pkg::M_BADNUM; consumed = 1'b1;
            end else if (b == sts_pkg::CH_DOT) begin
              dot_d = 1'b1; consumed = 1'b1;
            end else if (sts_pkg::is_digit(b)) consumed = 1'b1;
            else flushit = 1'b1;
          end
          sts_pkg::M_BADNUM: begin
            if (sts_pkg::is_alpha(b) || sts_pkg::is_digit(b) || b == sts_pkg::CH_DOT)
              consumed = 1'b1;
            else flushit = 1'b1;
          end
          sts_pkg::M_SLASH: begin
            if (b == sts_pkg::CH_SLASH) begin
              mode_d = sts_pkg::M_LINE; consumed = 1'b1;
            end else if (b == sts_pkg::CH_STAR) begin
              mode_d = sts_pkg::M_BLOCK; consumed = 1'b1;
            end else flushit = 1'b1;
          end
          sts_pkg::M_LINE: begin
            if (b != sts_pkg::CH_NL) consumed = 1'b1;
            else flushit = 1'b1;
          end
          sts_pkg::M_BLOCK, sts_pkg::M_BSTAR: begin
            consumed = 1'b1;
            if (mode_q == sts_pkg::M_BSTAR && b == sts_pkg::CH_SLASH) begin
              t0 = mk(sts_pkg::K_COMMENT, trow_q, tcol_q, glen); n = 2'd1;
              mode_d = sts_pkg::M_IDLE;
            end else mode_d = (b == sts_pkg::CH_STAR) ? sts_pkg::M_BSTAR : sts_pkg::M_BLOCK;
          end
          sts_pkg::M_STR2, sts_pkg::M_STR1: begin
            consumed = 1'b1;
            if (b == ((mode_q == sts_pkg::M_STR2) ? sts_pkg::CH_DQ : sts_pkg::CH_SQ)) begin
              t0 = mk(sts_pkg::K_STR, trow_q, tcol_q, glen); n = 2'd1;
              mode_d = sts_pkg::M_IDLE;
            end
          end
          default: consumed = 1'b0;
        endcase
        if (consumed) tlen_d = glen;
        if (flushit) begin
          t0 = tnew; n = 2'd1; mode_d = sts_pkg::M_IDLE;
        end
        if (!consumed && !sts_pkg::is_blank(b)) begin
          trow_d = row_q; tcol_d = c; tlen_d = LB'(1);
          if (sts_pkg::is_alpha(b) || b == sts_pkg::CH_US || b == sts_pkg::CH_DOLLAR) begin
            mode_d = sts_pkg::M_ID; wbuf_d[0] = b;
          end else if (sts_pkg::is_digit(b) || b == sts_pkg::CH_DOT) begin
            mode_d = sts_pkg::M_NUM; dot_d = b == sts_pkg::CH_DOT;
          end else if (b == sts_pkg::CH_SLASH) mode_d = sts_pkg::M_SLASH;
          else if (b == sts_pkg::CH_DQ) mode_d = sts_pkg::M_STR2;
          else if (b == sts_pkg::CH_SQ) mode_d = sts_pkg::M_STR1;
          else begin
            tnew = mk((pi == 4'd14) ? sts_pkg::K_UNDEF : sts_pkg::K_PUNCT0 + {1'b0, pi},
                      row_q, c, LB'(1));
            if (n == 2'd0) t0 = tnew; else t1 = tnew;
            n = n + 2'd1;
          end
        end
        if (b == sts_pkg::CH_NL) begin
          if (row_q != PosMax) row_d = row_q + 1'b1;
          col_d = '0;
        end else if (b == sts_pkg::CH_TAB) col_d = tsum[PB] ? PosMax : tsum[PB-1:0];
        else if (!(b == 8'd11 || b == 8'd12 || b == 8'd13)) col_d = c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tab_q <= sts_pkg::TabReset;
      mode_q <= sts_pkg::M_IDLE;
      row_q <= PB'(1); col_q <= '0; trow_q <= '0; tcol_q <= '0; tlen_q <= '0;
      dot_q <= 1'b0; eof_q <= 1'b0;
    end else begin
      if (cfg_we_i) tab_q <= cfg_data_i;
      if (acc) begin
        mode_q <= mode_d; row_q <= row_d; col_q <= col_d; trow_q <= trow_d;
        tcol_q <= tcol_d; tlen_q <= tlen_d; dot_q <= dot_d; eof_q <= eof_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) wbuf_q <= wbuf_d;
  end

  sts_pkg::token_t tout;
  sts_out_queue u_q (
    .clk_i(clk_i), .rst_ni(rst_ni), .push_i(acc), .cnt_i(n), .tok0_i(t0), .tok1_i(t1),
    .room_o(room), .valid_o(m_axis_tvalid), .ready_i(m_axis_tready), .tok_o(tout),
    .last_o(m_axis_tlast)
  );
  assign m_axis_tdata = {3'b0, tout.len, tout.col, tout.row, tout.kind};

`ifndef SYNTHESIS
  a_eof_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eof_q |-> mode_q == sts_pkg::M_IDLE) else $error("mode busy after end");
  a_eof_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    eof_q |=> eof_q) else $error("end flag dropped");
  a_row_nz: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q != '0) else $error("row zero");
`endif
endmodule
`default_nettype wire

[sim/tb_script_token_scanner_core.sv]
// Self-checking testbench for script_token_scanner_core: byte streams in, token
// stream checked against a built-in scanner model. Depends on sts_pkg and the core.
`default_nettype none
module tb_script_token_scanner_core;

  typedef struct {
    logic [4:0]  kind;
    logic [15:0] row;
    logic [15:0] col;
    logic [15:0] len;
    logic        last;
  } tok_rec_t;

  class token_scoreboard;
    tok_rec_t   expected_toks[$];
    tok_rec_t   run_toks[$];
    int         errors;
    int unsigned tab_cols;
    logic [3:0] mode;
    int unsigned row_cnt, col_cnt, t_row, t_col, t_len;
    logic [7:0] word_buf[sts_pkg::WordBytes];
    bit         dot_seen, eof_done;
    string      kw_names[10];

    function new();
      kw_names = '{"var", "const", "function", "if", "else", "while", "return",
                   "true", "false", "alert"};
      tab_cols = 32'(sts_pkg::TabReset);
      mode = sts_pkg::M_IDLE;
      row_cnt = 1;
      col_cnt = 0;
      t_row = 0;
      t_col = 0;
      t_len = 0;
      dot_seen = 0;
      eof_done = 0;
      errors = 0;
    endfunction

    function int unsigned sat(int unsigned v);
      return (v > 65535) ? 65535 : v;
    endfunction

    function void push_tok(logic [4:0] kind, int unsigned r, int unsigned c,
                           int unsigned len);
      tok_rec_t t;
      t.kind = kind;
      t.row = 16'(sat(r));
      t.col = 16'(sat(c));
      t.len = 16'(sat(len));
      t.last = 0;
      run_toks.push_back(t);
    endfunction

    function bit idch(logic [7:0] b);
      return sts_pkg::is_alpha(b) || sts_pkg::is_digit(b) || b == sts_pkg::CH_US
          || b == sts_pkg::CH_DOLLAR;
    endfunction

    function logic [4:0] word_kind();
      bit same;
      for (int k = 0; k < 10; k++) begin
        if (t_len != kw_names[k].len()) continue;
        same = 1;
        for (int i = 0; i < kw_names[k].len(); i++)
          if (word_buf[i] != kw_names[k][i]) same = 0;
        if (same) return 5'(k + 1);
      end
      return sts_pkg::K_ID;
    endfunction

    function void grow();
      if (t_len < 65535) t_len++;
    endfunction

    function void open_tok(logic [3:0] m, int unsigned r, int unsigned c);
      mode = m;
      t_row = r;
      t_col = c;
      t_len = 1;
    endfunction

    function void flush_pending();
      logic [4:0] k;
      case (mode)
        sts_pkg::M_IDLE: return;
        sts_pkg::M_ID: k = word_kind();
        sts_pkg::M_NUM: k = dot_seen ? sts_pkg::K_DEC : sts_pkg::K_INT;
        sts_pkg::M_SLASH: k = sts_pkg::K_DIV;
        sts_pkg::M_LINE: k = sts_pkg::K_COMMENT;
        default: k = sts_pkg::K_UNDEF;
      endcase
      push_tok(k, t_row, t_col, t_len);
      mode = sts_pkg::M_IDLE;
    endfunction

    function void start_tok(logic [7:0] b, int unsigned r, int unsigned c);
      logic [3:0] p;
      p = sts_pkg::punct_idx(b);
      if (sts_pkg::is_blank(b)) return;
      if (sts_pkg::is_alpha(b) || b == sts_pkg::CH_US || b == sts_pkg::CH_DOLLAR) begin
        open_tok(sts_pkg::M_ID, r, c);
        word_buf[0] = b;
      end else if (sts_pkg::is_digit(b) || b == sts_pkg::CH_DOT) begin
        open_tok(sts_pkg::M_NUM, r, c);
        dot_seen = (b == sts_pkg::CH_DOT);
      end else if (b == sts_pkg::CH_SLASH) open_tok(sts_pkg::M_SLASH, r, c);
      else if (b == sts_pkg::CH_DQ) open_tok(sts_pkg::M_STR2, r, c);
      else if (b == sts_pkg::CH_SQ) open_tok(sts_pkg::M_STR1, r, c);
      else if (p != 4'd14) push_tok(sts_pkg::K_PUNCT0 + 5'(p), r, c, 1);
      else push_tok(sts_pkg::K_UNDEF, r, c, 1);
    endfunction

    // Returns 1 when the byte was taken by the pending token.
    function bit feed_tok(logic [7:0] b);
      case (mode)
        sts_pkg::M_ID: if (idch(b)) begin
          if (t_len < sts_pkg::WordBytes) word_buf[t_len] = b;
          grow();
          return 1;
        end
        sts_pkg::M_NUM: begin
          if (sts_pkg::is_alpha(b) || (b == sts_pkg::CH_DOT && dot_seen))
            mode = sts_pkg::M_BADNUM;
          else if (b == sts_pkg::CH_DOT) dot_seen = 1;
          if (sts_pkg::is_alpha(b) || sts_pkg::is_digit(b) || b == sts_pkg::CH_DOT) begin
            grow();
            return 1;
          end
        end
        sts_pkg::M_BADNUM:
          if (sts_pkg::is_alpha(b) || sts_pkg::is_digit(b) || b == sts_pkg::CH_DOT) begin
            grow();
            return 1;
          end
        sts_pkg::M_SLASH: if (b == sts_pkg::CH_SLASH || b == sts_pkg::CH_STAR) begin
          mode = (b == sts_pkg::CH_SLASH) ? sts_pkg::M_LINE : sts_pkg::M_BLOCK;
          grow();
          return 1;
        end
        sts_pkg::M_LINE: if (b != sts_pkg::CH_NL) begin
          grow();
          return 1;
        end
        sts_pkg::M_BLOCK, sts_pkg::M_BSTAR: begin
          grow();
          if (mode == sts_pkg::M_BSTAR && b == sts_pkg::CH_SLASH) begin
            push_tok(sts_pkg::K_COMMENT, t_row, t_col, t_len);
            mode = sts_pkg::M_IDLE;
          end else mode = (b == sts_pkg::CH_STAR) ? sts_pkg::M_BSTAR : sts_pkg::M_BLOCK;
          return 1;
        end
        sts_pkg::M_STR2, sts_pkg::M_STR1: begin
          grow();
          if (b == ((mode == sts_pkg::M_STR2) ? sts_pkg::CH_DQ : sts_pkg::CH_SQ)) begin
            push_tok(sts_pkg::K_STR, t_row, t_col, t_len);
            mode = sts_pkg::M_IDLE;
          end
          return 1;
        end
        default: return 0;
      endcase
      flush_pending();
      return 0;
    endfunction

    function void note_request(logic [7:0] b, logic eot);
      int unsigned r, c;
      r = row_cnt;
      c = (col_cnt < 65535) ? col_cnt + 1 : 65535;
      run_toks.delete();
      if (eof_done) return;
      if (eot) begin
        flush_pending();
        push_tok(sts_pkg::K_EOF, r, c, 0);
        eof_done = 1;
      end else begin
        if (!feed_tok(b)) start_tok(b, r, c);
        if (b == sts_pkg::CH_NL) begin
          if (row_cnt < 65535) row_cnt++;
          col_cnt = 0;
        end else if (b == sts_pkg::CH_TAB) begin
          col_cnt = (65535 - col_cnt < tab_cols) ? 65535 : col_cnt + tab_cols;
        end else if (!(b == 8'd11 || b == 8'd12 || b == 8'd13)) col_cnt = c;
      end
      if (run_toks.size() > 0) run_toks[run_toks.size() - 1].last = 1;
      foreach (run_toks[i]) expected_toks.push_back(run_toks[i]);
    endfunction

    function void check_token(logic [55:0] data, logic last);
      tok_rec_t e;
      if (expected_toks.size() == 0) begin
        $error("unexpected token %h last %0b", data, last);
        errors++;
        return;
      end
      e = expected_toks.pop_front();
      if (data[4:0] != e.kind) begin
        $error("token_kind: expected %0d, got %0d", e.kind, data[4:0]);
        errors++;
      end
      if (data[20:5] != e.row) begin
        $error("start_row: expected %0d, got %0d", e.row, data[20:5]);
        errors++;
      end
      if (data[36:21] != e.col) begin
        $error("start_col: expected %0d, got %0d", e.col, data[36:21]);
        errors++;
      end
      if (data[52:37] != e.len) begin
        $error("token_length: expected %0d, got %0d", e.len, data[52:37]);
        errors++;
      end
      if (last != e.last) begin
        $error("last_of_run: expected %0b, got %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i, rst_ni;
  logic        cfg_we_i;
  logic [4:0]  cfg_data_i;
  logic        s_axis_tvalid, s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid, m_axis_tready;
  logic [55:0] m_axis_tdata;
  logic        m_axis_tlast;

  token_scoreboard sb;
  int unsigned idle_pct, stall_pct;
  bit          hold_req;
  int unsigned sent_bytes;

  script_token_scanner_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #50_000_000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready) sb.note_request(s_axis_tdata, s_axis_tuser);
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_token(m_axis_tdata, m_axis_tlast);
  end

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    m_axis_tready = 0;
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        hold_req = 0;
        m_axis_tready <= 0;
        repeat (300) @(negedge clk_i);
      end
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic send_byte(logic [7:0] b, logic eot);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= eot;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
    sent_bytes++;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], 0);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.expected_toks.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_tab(logic [4:0] v);
    cfg_we_i   <= 1;
    cfg_data_i <= v;
    @(posedge clk_i);
    sb.tab_cols = 32'(v);
    @(negedge clk_i);
    cfg_we_i <= 0;
  endtask

  function automatic string rand_word();
    string s;
    string chars;
    chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_$0123456789";
    s = "";
    s = {s, string'(chars[$urandom_range(53)])};
    repeat ($urandom_range(11)) s = {s, string'(chars[$urandom_range(63)])};
    return s;
  endfunction

  function automatic string rand_fragment();
    string s;
    string kws[10];
    string marks;
    kws = '{"var", "const", "function", "if", "else", "while", "return", "true",
            "false", "alert"};
    marks = "()*+-/;<=>[]{}";
    s = "";
    case ($urandom_range(11))
      0, 1: s = kws[$urandom_range(9)];
      2: s = rand_word();
      3: begin
        repeat ($urandom_range(1, 4)) s = {s, string'(8'd48 + 8'($urandom_range(9)))};
        if ($urandom_range(1)) s = {s, "."};
        repeat ($urandom_range(2)) s = {s, string'(8'd48 + 8'($urandom_range(9)))};
        if ($urandom_range(3) == 0) s = {s, ($urandom_range(1) ? "." : "e"), "7"};
      end
      4: begin
        s = $urandom_range(1) ? "\"" : "'";
        s = {s, rand_word(), " ", s};
      end
      5: s = {"//", rand_word(), "\n"};
      6: s = {"/*", ($urandom_range(1) ? "***" : " x\n"), rand_word(), "**/"};
      7: s = string'(marks[$urandom_range(13)]);
      8: s = {"/", rand_word()};
      9: s = $urandom_range(1) ? "\t" : "\n";
      10: s = {" ", string'(8'($urandom_range(11, 13)))};
      default: repeat ($urandom_range(1, 3)) s = {s, string'(8'($urandom_range(1, 255)))};
    endcase
    return {s, " "};
  endfunction

  task automatic random_phase(int unsigned idle, int unsigned stall, int unsigned n,
                              bit hold);
    int unsigned start;
    string frag;
    idle_pct = idle;
    stall_pct = stall;
    hold_req = hold;
    start = sent_bytes;
    while (sent_bytes - start < n) begin
      frag = rand_fragment();
      send_text(frag);
      if ($urandom_range(19) == 0) send_byte(8'($urandom_range(255)), 0);
      if ($urandom_range(40) == 0) send_byte(8'h00, 0);
    end
    drain();
  endtask

  initial begin
    sb = new();
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_data_i = '0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    s_axis_tuser = 0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    sent_bytes = 0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: numbers, bad number, division, both comment kinds, star runs,
    // both quotes, marks, unknown bytes and the blanks.
    send_text("if x1 9.5..a .;/y//c\n/***/'q'\"\"(#\t\r");
    send_byte(8'd11, 0);
    send_byte(8'd12, 0);
    send_byte(8'hff, 0);
    drain();

    write_tab(5'd1);
    random_phase(0, 0, 160, 1);
    write_tab(5'd16);
    random_phase(86, 0, 160, 0);
    write_tab(5'd0);
    random_phase(0, 86, 160, 1);
    write_tab(5'd31);
    random_phase(25, 25, 160, 0);

    // Unterminated string at end of file, then a byte that must be ignored.
    idle_pct = 0;
    stall_pct = 0;
    send_text("w \"open");
    send_byte(8'h00, 1);
    send_byte("x", 0);
    drain();

    if (sb.errors == 0 && sb.expected_toks.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
`default_nettype wire

[script_token_scanner_core.f]
src/sts_pkg.sv
src/sts_keyword.sv
src/sts_out_queue.sv
src/script_token_scanner_core.sv
sim/tb_script_token_scanner_core.sv
